### hw/rtl/hsm_pkg.sv
// ----------------------------------------------------------------------------
// Handle slot map package
// Sizes, operation codes and status codes shared by the slot map and its
// port checker.
// ----------------------------------------------------------------------------
package hsm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

endpackage

### hw/rtl/hsm_ram.sv
// ----------------------------------------------------------------------------
// Slot map RAM
// Simple dual-port memory: one write port, one read port with registered
// read data. A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module hsm_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/handle_slot_map.sv
// ----------------------------------------------------------------------------
// Handle slot map
// Packed table of 32-bit keys reached through stable handles.
// ----------------------------------------------------------------------------
// A command is transferred at a rising edge with start high and busy low;
// mode_i, key_i and handle_i are sampled at that edge. Exactly one result
// follows, shown on status_o, slot_o, handle_out_o and live_count_o for one
// cycle with done_o high. The receiver cannot stall, so the result is taken
// in that cycle and busy is already low again, letting the next command in.
//
// Steps from the start transfer to done_o:
//   allocate on a full table, destroy on an empty table, unused mode: answered from idle
//   allocate: one read of the slot-to-handle RAM
//   destroy: a map read; for a live handle then reads and two writes
//   find: walks the live slots up to a hit, or all of them on a miss
// Find dominates: one shared 32-bit comparator walks the live slots while
// the key RAM streams one slot per cycle, so a miss on a full table takes
// longest.
//
// After reset the block runs a pass over all 64 slots that loads both maps
// with the identity and clears the keys; busy is high for its duration.
// ----------------------------------------------------------------------------
module handle_slot_map
  import hsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [SLOT_W-1:0]   handle_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [SLOT_W-1:0]   handle_out_o,
  output logic [COUNT_W-1:0]  live_count_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_DEL_MAP,
    ST_DEL_WR1,
    ST_DEL_WR2,
    ST_FIND
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] count_q;
  logic [KEY_W-1:0]   key_q;
  logic [SLOT_W-1:0]  hin_q;
  logic [SLOT_W-1:0]  dst_q;
  logic [SLOT_W-1:0]  hsrc_q;
  logic [SLOT_W-1:0]  clr_q;
  logic [COUNT_W:0]   rd_idx_q;
  logic               cmp_valid_q;
  logic [SLOT_W-1:0]  cmp_idx_q;

  logic               key_we, h2s_we, s2h_we;
  logic [SLOT_W-1:0]  key_waddr, h2s_waddr, s2h_waddr;
  logic [KEY_W-1:0]   key_wdata;
  logic [SLOT_W-1:0]  h2s_wdata, s2h_wdata;
  logic [SLOT_W-1:0]  key_raddr, h2s_raddr, s2h_raddr;
  logic [KEY_W-1:0]   key_rd;
  logic [SLOT_W-1:0]  h2s_rd, s2h_rd;

  logic [SLOT_W-1:0]  src_slot;
  logic               accept;
  logic               is_full;
  logic               key_hit;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count_q == COUNT_W'(MAX_ENTRIES));
  assign src_slot = SLOT_W'(count_q - COUNT_W'(1));
  // The single comparator shared by every step of a find.
  assign key_hit  = cmp_valid_q && (key_rd == key_q);

  always_comb begin
    key_we    = 1'b0;
    h2s_we    = 1'b0;
    s2h_we    = 1'b0;
    key_waddr = dst_q;
    key_wdata = key_rd;
    h2s_waddr = hin_q;
    h2s_wdata = src_slot;
    s2h_waddr = dst_q;
    s2h_wdata = s2h_rd;
    key_raddr = rd_idx_q[SLOT_W-1:0];
    s2h_raddr = rd_idx_q[SLOT_W-1:0];
    h2s_raddr = handle_i;
    unique case (state_q)
      ST_CLEAR: begin
        key_we    = 1'b1;
        h2s_we    = 1'b1;
        s2h_we    = 1'b1;
        key_waddr = clr_q;
        key_wdata = '0;
        h2s_waddr = clr_q;
        h2s_wdata = clr_q;
        s2h_waddr = clr_q;
        s2h_wdata = clr_q;
      end
      ST_IDLE: begin
        key_we    = accept && (mode_i == MODE_ALLOC) && !is_full;
        key_waddr = count_q[SLOT_W-1:0];
        key_wdata = key_i;
        s2h_raddr = count_q[SLOT_W-1:0];
      end
      ST_DEL_MAP: begin
        key_raddr = src_slot;
        s2h_raddr = src_slot;
      end
      ST_DEL_WR1: begin
        // Move the last live entry into the freed slot.
        key_we = 1'b1;
        h2s_we = 1'b1;
        s2h_we = 1'b1;
      end
      ST_DEL_WR2: begin
        key_we    = 1'b1;
        h2s_we    = 1'b1;
        s2h_we    = 1'b1;
        key_waddr = src_slot;
        key_wdata = '0;
        h2s_waddr = hsrc_q;
        h2s_wdata = dst_q;
        s2h_waddr = src_slot;
        s2h_wdata = hin_q;
      end
      ST_ALLOC_RD, ST_FIND: begin
      end
      default: begin
      end
    endcase
  end

  hsm_ram #(.DATA_W(KEY_W), .ADDR_W(SLOT_W)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rd)
  );

  hsm_ram #(.DATA_W(SLOT_W), .ADDR_W(SLOT_W)) u_h2s_ram (
    .clk_i   (clk_i),
    .we_i    (h2s_we),
    .waddr_i (h2s_waddr),
    .wdata_i (h2s_wdata),
    .raddr_i (h2s_raddr),
    .rdata_o (h2s_rd)
  );

  hsm_ram #(.DATA_W(SLOT_W), .ADDR_W(SLOT_W)) u_s2h_ram (
    .clk_i   (clk_i),
    .we_i    (s2h_we),
    .waddr_i (s2h_waddr),
    .wdata_i (s2h_wdata),
    .raddr_i (s2h_raddr),
    .rdata_o (s2h_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      count_q      <= '0;
      key_q        <= '0;
      hin_q        <= '0;
      dst_q        <= '0;
      hsrc_q       <= '0;
      clr_q        <= '0;
      rd_idx_q     <= '0;
      cmp_valid_q  <= 1'b0;
      cmp_idx_q    <= '0;
      done_o       <= 1'b0;
      status_o     <= STATUS_OK;
      slot_o       <= '0;
      handle_out_o <= '0;
      live_count_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SLOT_W'(1);
          if (clr_q == SLOT_W'(MAX_ENTRIES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            key_q        <= key_i;
            hin_q        <= handle_i;
            status_o     <= STATUS_OK;
            slot_o       <= '0;
            handle_out_o <= '0;
            live_count_o <= count_q;
            unique case (mode_i)
              MODE_ALLOC: begin
                if (is_full) begin
                  done_o   <= 1'b1;
                  status_o <= STATUS_FULL;
                end else begin
                  state_q <= ST_ALLOC_RD;
                end
              end
              MODE_DESTROY: begin
                if (count_q == '0) begin
                  done_o   <= 1'b1;
                  status_o <= STATUS_EMPTY;
                end else begin
                  state_q <= ST_DEL_MAP;
                end
              end
              MODE_FIND: begin
                rd_idx_q    <= '0;
                cmp_valid_q <= 1'b0;
                state_q     <= ST_FIND;
              end
              MODE_NONE: begin
                done_o <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ALLOC_RD: begin
          count_q      <= count_q + COUNT_W'(1);
          done_o       <= 1'b1;
          slot_o       <= count_q[SLOT_W-1:0];
          handle_out_o <= s2h_rd;
          live_count_o <= count_q + COUNT_W'(1);
          state_q      <= ST_IDLE;
        end
        ST_DEL_MAP: begin
          dst_q <= h2s_rd;
          if ({1'b0, h2s_rd} >= count_q) begin
            // The handle points past the live entries: it is dead.
            done_o   <= 1'b1;
            status_o <= STATUS_NOT_FOUND;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_DEL_WR1;
          end
        end
        ST_DEL_WR1: begin
          hsrc_q  <= s2h_rd;
          state_q <= ST_DEL_WR2;
        end
        ST_DEL_WR2: begin
          count_q      <= count_q - COUNT_W'(1);
          done_o       <= 1'b1;
          slot_o       <= dst_q;
          handle_out_o <= hin_q;
          live_count_o <= count_q - COUNT_W'(1);
          state_q      <= ST_IDLE;
        end
        ST_FIND: begin
          // Reads run one slot ahead of the compare.
          rd_idx_q    <= rd_idx_q + (COUNT_W+1)'(1);
          cmp_valid_q <= (rd_idx_q < {1'b0, count_q});
          cmp_idx_q   <= rd_idx_q[SLOT_W-1:0];
          if (key_hit) begin
            done_o       <= 1'b1;
            slot_o       <= cmp_idx_q;
            handle_out_o <= s2h_rd;
            state_q      <= ST_IDLE;
          end else if (!cmp_valid_q && (rd_idx_q >= {1'b0, count_q})) begin
            done_o   <= 1'b1;
            status_o <= STATUS_NOT_FOUND;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/hsm_checker.sv
// ----------------------------------------------------------------------------
// Handle slot map port checker
// Watches the ports of the slot map and flags results that break its
// command and result rules.
// ----------------------------------------------------------------------------
module hsm_checker
  import hsm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [SLOT_W-1:0]   slot_o,
  input logic [SLOT_W-1:0]   handle_out_o,
  input logic [COUNT_W-1:0]  live_count_o
);

  // Every accepted command either answers at once or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o || busy)
    else $error("command transfer left the block idle without a result");

  // A result always returns the block to the ready state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> live_count_o <= COUNT_W'(MAX_ENTRIES))
    else $error("live count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STATUS_FULL) |->
      live_count_o == COUNT_W'(MAX_ENTRIES) && slot_o == '0 && handle_out_o == '0)
    else $error("full status with a table that is not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STATUS_EMPTY) |-> live_count_o == '0)
    else $error("empty status with live entries");

endmodule

bind handle_slot_map hsm_checker u_hsm_checker (.*);

### bench/tb.sv
// ----------------------------------------------------------------------------
// Handle slot map testbench
// Drives allocate, destroy and find commands into the slot map and checks
// every result against a shadow copy of the handle maps and the key table
// or a result typed into the plan. Directed commands come first: the empty
// and full table, dead handles, lookups that miss and the swap done by
// destroy. A long random run follows that fills and drains the table in waves.
// ----------------------------------------------------------------------------
module tb;
  import hsm_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PLAN_ROWS    = 20;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   handle_out;
    logic [COUNT_W-1:0]  live_count;
  } map_result_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] handle;
    int                reps;
    bit                random_key;
    bit                typed;
    map_result_t       result;
  } plan_row_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                start    = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   mode_i   = MODE_NONE;
  logic [KEY_W-1:0]    key_i    = '0;
  logic [SLOT_W-1:0]   handle_i = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [SLOT_W-1:0]   handle_out_o;
  logic [COUNT_W-1:0]  live_count_o;

  // Shadow copy of the block's state.
  logic [SLOT_W-1:0] slot_of_handle [MAX_ENTRIES];
  logic [SLOT_W-1:0] handle_of_slot [MAX_ENTRIES];
  logic [KEY_W-1:0]  key_at_slot    [MAX_ENTRIES];
  int unsigned       live_entries;

  map_result_t expected_results [$];
  plan_row_t   plan [PLAN_ROWS];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  int unsigned idle_pct     = 0;

  handle_slot_map i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .handle_i    (handle_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .slot_o      (slot_o),
    .handle_out_o(handle_out_o),
    .live_count_o(live_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic map_result_t apply_map_op(logic [MODE_W-1:0] mode,
                                               logic [KEY_W-1:0] key,
                                               logic [SLOT_W-1:0] handle);
    map_result_t       res;
    logic [SLOT_W-1:0] dst;
    logic [SLOT_W-1:0] src;
    logic [SLOT_W-1:0] moved;
    bit                found;
    res   = '0;
    found = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        if (live_entries >= MAX_ENTRIES) begin
          res.status = STATUS_FULL;
        end else begin
          res.slot       = SLOT_W'(live_entries);
          res.handle_out = handle_of_slot[live_entries];
          key_at_slot[live_entries] = key;
          live_entries++;
        end
      end
      MODE_DESTROY: begin
        if (live_entries == 0) begin
          res.status = STATUS_EMPTY;
        end else if (slot_of_handle[handle] >= live_entries) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          // The last live entry fills the hole and the two maps swap.
          dst   = slot_of_handle[handle];
          src   = SLOT_W'(live_entries - 1);
          moved = handle_of_slot[src];
          live_entries--;
          key_at_slot[dst]      = key_at_slot[src];
          key_at_slot[src]      = '0;
          slot_of_handle[handle] = src;
          slot_of_handle[moved]  = dst;
          handle_of_slot[dst]    = moved;
          handle_of_slot[src]    = handle;
          res.slot       = dst;
          res.handle_out = handle;
        end
      end
      MODE_FIND: begin
        res.status = STATUS_NOT_FOUND;
        for (int i = 0; i < int'(live_entries) && !found; i++) begin
          if (key_at_slot[i] == key) begin
            found          = 1'b1;
            res.status     = STATUS_OK;
            res.slot       = SLOT_W'(i);
            res.handle_out = handle_of_slot[i];
          end
        end
      end
      default: begin
      end
    endcase
    res.live_count = COUNT_W'(live_entries);
    return res;
  endfunction

  // Small keys repeat often, so find also meets duplicates.
  function automatic logic [KEY_W-1:0] draw_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return KEY_W'($urandom_range(15));
    if (r < 45) return '0;
    if (r < 50) return '1;
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < 40) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Presents one command, holds it until the transfer and records its result.
  task automatic issue(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                       input logic [SLOT_W-1:0] handle, input bit typed,
                       input map_result_t typed_res);
    map_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    mode_i   <= mode;
    key_i    <= key;
    handle_i <= handle;
    do @(posedge clk_i); while (busy);
    predicted = apply_map_op(mode, key, handle);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    map_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", status_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (slot_o !== want.slot) report_mismatch("slot", slot_o, want.slot);
        if (handle_out_o !== want.handle_out) begin
          report_mismatch("handle_out", handle_out_o, want.handle_out);
        end
        if (live_count_o !== want.live_count) begin
          report_mismatch("live_count", live_count_o, want.live_count);
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb failed");
    $finish;
  end

  initial begin
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] handle;
    int unsigned       fill_pct;
    int unsigned       r;

    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_of_handle[i] = SLOT_W'(i);
      handle_of_slot[i] = SLOT_W'(i);
      key_at_slot[i]    = '0;
    end
    live_entries = 0;
    fill_pct     = 50;

    plan[0]  = '{MODE_DESTROY, 32'h0, 6'd0, 1, 1'b0, 1'b1, '{STATUS_EMPTY, 6'd0, 6'd0, 7'd0}};
    plan[1]  = '{MODE_FIND, 32'h0, 6'd0, 1, 1'b0, 1'b1, '{STATUS_NOT_FOUND, 6'd0, 6'd0, 7'd0}};
    plan[2]  = '{MODE_NONE, 32'hFFFF_FFFF, 6'd63, 1, 1'b0, 1'b1,
                 '{STATUS_OK, 6'd0, 6'd0, 7'd0}};
    plan[3]  = '{MODE_ALLOC, 32'hFFFF_FFFF, 6'd0, 1, 1'b0, 1'b1,
                 '{STATUS_OK, 6'd0, 6'd0, 7'd1}};
    plan[4]  = '{MODE_ALLOC, 32'h0, 6'd0, 1, 1'b0, 1'b1, '{STATUS_OK, 6'd1, 6'd1, 7'd2}};
    plan[5]  = '{MODE_FIND, 32'h0, 6'd0, 1, 1'b0, 1'b1, '{STATUS_OK, 6'd1, 6'd1, 7'd2}};
    plan[6]  = '{MODE_FIND, 32'hFFFF_FFFF, 6'd0, 1, 1'b0, 1'b1,
                 '{STATUS_OK, 6'd0, 6'd0, 7'd2}};
    plan[7]  = '{MODE_DESTROY, 32'h0, 6'd63, 1, 1'b0, 1'b1,
                 '{STATUS_NOT_FOUND, 6'd0, 6'd0, 7'd2}};
    // Destroying slot 0 pulls the last entry down into it.
    plan[8]  = '{MODE_DESTROY, 32'h0, 6'd0, 1, 1'b0, 1'b1, '{STATUS_OK, 6'd0, 6'd0, 7'd1}};
    plan[9]  = '{MODE_FIND, 32'hFFFF_FFFF, 6'd0, 1, 1'b0, 1'b1,
                 '{STATUS_NOT_FOUND, 6'd0, 6'd0, 7'd1}};
    plan[10] = '{MODE_FIND, 32'h0, 6'd0, 1, 1'b0, 1'b1, '{STATUS_OK, 6'd0, 6'd1, 7'd1}};
    plan[11] = '{MODE_DESTROY, 32'h0, 6'd0, 1, 1'b0, 1'b1,
                 '{STATUS_NOT_FOUND, 6'd0, 6'd0, 7'd1}};
    plan[12] = '{MODE_ALLOC, 32'h5A5A_5A5A, 6'd63, 1, 1'b0, 1'b1,
                 '{STATUS_OK, 6'd1, 6'd0, 7'd2}};
    plan[13] = '{MODE_ALLOC, 32'h0, 6'd0, 62, 1'b1, 1'b0, '0};
    plan[14] = '{MODE_ALLOC, 32'hA5A5_A5A5, 6'd0, 1, 1'b0, 1'b1,
                 '{STATUS_FULL, 6'd0, 6'd0, 7'd64}};
    plan[15] = '{MODE_FIND, 32'hA5A5_A5A5, 6'd0, 1, 1'b0, 1'b0, '0};
    plan[16] = '{MODE_NONE, 32'h0, 6'd0, 1, 1'b0, 1'b1, '{STATUS_OK, 6'd0, 6'd0, 7'd64}};
    plan[17] = '{MODE_DESTROY, 32'h0, 6'd63, 1, 1'b0, 1'b1,
                 '{STATUS_OK, 6'd63, 6'd63, 7'd63}};
    plan[18] = '{MODE_DESTROY, 32'h0, 6'd63, 1, 1'b0, 1'b1,
                 '{STATUS_NOT_FOUND, 6'd0, 6'd0, 7'd63}};
    plan[19] = '{MODE_FIND, 32'h5A5A_5A5A, 6'd0, 1, 1'b0, 1'b1,
                 '{STATUS_OK, 6'd1, 6'd0, 7'd63}};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 32;
    foreach (plan[p]) begin
      for (int n = 0; n < plan[p].reps; n++) begin
        key = plan[p].random_key ? $urandom : plan[p].key;
        issue(plan[p].mode, key, plan[p].handle, plan[p].typed, plan[p].result);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n < RANDOM_ITEMS / 3) ? 32 : (n < 2 * RANDOM_ITEMS / 3) ? 83 : 0;
      // The fill bias changes in waves so the table both empties and fills up.
      if (n % 64 == 0) begin
        r = $urandom_range(9);
        fill_pct = (r == 0) ? 0 : (r == 1) ? 100 : $urandom_range(80, 20);
      end
      key    = draw_key();
      handle = SLOT_W'($urandom_range(63));
      r      = $urandom_range(99);
      if (r < 3) begin
        mode = MODE_NONE;
      end else if (r < 30) begin
        mode = MODE_FIND;
        if (live_entries > 0 && $urandom_range(99) < 60) begin
          key = key_at_slot[$urandom_range(live_entries - 1)];
        end
      end else if ($urandom_range(99) < fill_pct) begin
        mode = MODE_ALLOC;
      end else begin
        mode = MODE_DESTROY;
        if (live_entries > 0 && $urandom_range(99) < 85) begin
          handle = handle_of_slot[$urandom_range(live_entries - 1)];
        end
      end
      issue(mode, key, handle, 1'b0, '0);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
